/* rtl/core/clws_pkg.sv */
// ----------------------------------------------------------------------------
// Character LCD write sequencer package
// Shared widths, command codes, job type and power-up tables.
// ----------------------------------------------------------------------------
package clws_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ROW_W    = 3;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned WAIT_W   = 15;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [ACTION_W-1:0] ACT_COMMAND = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DATA    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POSDATA = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POWERUP = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_GLYPH   = 3'd4;

  localparam logic [BYTE_W-1:0] CMD_FUNC_8BIT = 8'h38;
  localparam logic [BYTE_W-1:0] CMD_FUNC_4BIT = 8'h28;
  localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_HOME      = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;
  localparam logic [BYTE_W-1:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [BYTE_W-1:0] CMD_DDRAM     = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_CGRAM     = 8'h40;

  localparam logic [BYTE_W-1:0] ROW1_BASE = 8'h80;
  localparam logic [BYTE_W-1:0] ROW2_BASE = 8'hC0;
  localparam logic [BYTE_W-1:0] ROW3_BASE = 8'h94;
  localparam logic [BYTE_W-1:0] ROW4_BASE = 8'hD4;

  localparam logic [WAIT_W-1:0] WAIT_POWER_ON = 15'd20000;
  localparam logic [WAIT_W-1:0] WAIT_SECOND   = 15'd5000;
  localparam logic [WAIT_W-1:0] WAIT_THIRD    = 15'd150;

  localparam logic [IDX_W-1:0] INIT_LAST = 4'd8;

  localparam logic [APB_AW-1:0] REG_FOUR_BIT = 3'd0;
  localparam logic [APB_AW-1:0] REG_PULSE_US = 3'd4;

  localparam logic [BYTE_W-1:0] PULSE_US_RST = 8'd10;

  typedef enum logic [1:0] {
    JOB_ONE,
    JOB_TWO,
    JOB_INIT
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic              rs0;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
  } clws_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } clws_queue_status_t;

  function automatic logic [BYTE_W-1:0] row_base(input logic [ROW_W-1:0] row);
    logic [BYTE_W-1:0] base;
    unique case (row)
      3'd1:    base = ROW1_BASE;
      3'd2:    base = ROW2_BASE;
      3'd3:    base = ROW3_BASE;
      default: base = ROW4_BASE;
    endcase
    return base;
  endfunction

  function automatic logic [BYTE_W-1:0] init_byte(input logic [IDX_W-1:0] idx,
                                                  input logic four_bit);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      4'd0, 4'd1, 4'd2: b = CMD_FUNC_8BIT;
      4'd3:             b = CMD_CLEAR;
      4'd4:             b = CMD_HOME;
      4'd5:             b = CMD_ENTRY;
      4'd6:             b = CMD_DISP_ON;
      4'd7:             b = four_bit ? CMD_FUNC_4BIT : CMD_FUNC_8BIT;
      default:          b = CMD_DDRAM;
    endcase
    return b;
  endfunction

  function automatic logic [WAIT_W-1:0] init_wait(input logic [IDX_W-1:0] idx);
    logic [WAIT_W-1:0] w;
    unique case (idx)
      4'd0:    w = WAIT_POWER_ON;
      4'd1:    w = WAIT_SECOND;
      4'd2:    w = WAIT_THIRD;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/clws_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one display request per transfer.
// ----------------------------------------------------------------------------
interface clws_req_if;
  import clws_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   value;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    column;
  logic [SLOT_W-1:0]   glyph_slot;

  modport source (output valid, action, value, row, column, glyph_slot, input ready);
  modport sink (input valid, action, value, row, column, glyph_slot, output ready);
endinterface

/* rtl/core/clws_stb_if.sv */
// ----------------------------------------------------------------------------
// Strobe channel
// Valid/ready channel that carries one bus strobe per transfer.
// ----------------------------------------------------------------------------
interface clws_stb_if;
  import clws_pkg::*;

  logic              valid;
  logic              ready;
  logic              register_select;
  logic [BYTE_W-1:0] bus_value;
  logic [WAIT_W-1:0] wait_before_us;
  logic              last;

  modport source (output valid, register_select, bus_value, wait_before_us, last,
                  input ready);
  modport sink (input valid, register_select, bus_value, wait_before_us, last,
                output ready);
endinterface

/* rtl/core/clws_front.sv */
// ----------------------------------------------------------------------------
// Request decoder
// Accepts requests and turns each one with a known action into a job for the strobe generator.
// ----------------------------------------------------------------------------
module clws_front
  import clws_pkg::*;
(
  clws_req_if.sink           req,
  input  clws_queue_status_t status_i,
  output logic               push_o,
  output clws_job_t          job_o
);

  logic [BYTE_W-1:0] cursor_addr;

  assign req.ready   = ~status_i.full;
  assign cursor_addr = row_base(req.row) + {{(BYTE_W-COL_W){1'b0}}, req.column} - 8'd1;

  always_comb begin
    job_o = '{kind: JOB_ONE, rs0: 1'b0, byte0: req.value, byte1: req.value};
    push_o = req.valid & ~status_i.full;
    unique case (req.action)
      ACT_COMMAND: begin
        job_o.rs0 = 1'b0;
      end
      ACT_DATA: begin
        job_o.rs0 = 1'b1;
      end
      ACT_POSDATA: begin
        if (req.row >= 3'd1 && req.row <= 3'd4) begin
          job_o.kind  = JOB_TWO;
          job_o.byte0 = cursor_addr;
        end else begin
          job_o.rs0 = 1'b1;
        end
      end
      ACT_POWERUP: begin
        job_o.kind = JOB_INIT;
      end
      ACT_GLYPH: begin
        job_o.byte0 = CMD_CGRAM | {2'b00, req.glyph_slot, 3'b000};
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/clws_fifo.sv */
// ----------------------------------------------------------------------------
// Job queue
// Small register queue that decouples request decoding from strobe output.
// ----------------------------------------------------------------------------
module clws_fifo
  import clws_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  clws_job_t          job_i,
  input  logic               pop_i,
  output clws_job_t          head_o,
  output logic               head_valid_o,
  output clws_queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  clws_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == CntFull);
  assign status_o.empty = (count_q == '0);
  assign head_valid_o   = ~status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* rtl/core/clws_back.sv */
// ----------------------------------------------------------------------------
// Strobe generator
// Walks the job at the queue head and issues its strobes through an output
// register, one strobe per cycle while the sink takes them.
// ----------------------------------------------------------------------------
module clws_back
  import clws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      four_bit_i,
  input  logic      head_valid_i,
  input  clws_job_t head_i,
  output logic      pop_o,
  clws_stb_if.source stb
);

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              nib_q, nib_d;
  logic              valid_q, valid_d;
  logic              rs_q, rs_d;
  logic [BYTE_W-1:0] bus_q, bus_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic              last_q, last_d;

  logic [IDX_W-1:0]  last_idx;
  logic [BYTE_W-1:0] cur_byte;
  logic [WAIT_W-1:0] cur_wait;
  logic              cur_rs;
  logic              byte_done;
  logic              strobe_last;
  logic              load;

  always_comb begin
    cur_wait = '0;
    unique case (head_i.kind)
      JOB_TWO: begin
        last_idx = 4'd1;
        cur_byte = (idx_q == '0) ? head_i.byte0 : head_i.byte1;
        cur_rs   = (idx_q == '0) ? head_i.rs0 : 1'b1;
      end
      JOB_INIT: begin
        last_idx = INIT_LAST;
        cur_byte = init_byte(idx_q, four_bit_i);
        cur_rs   = 1'b0;
        cur_wait = init_wait(idx_q);
      end
      default: begin
        last_idx = '0;
        cur_byte = head_i.byte0;
        cur_rs   = head_i.rs0;
      end
    endcase

    byte_done   = ~four_bit_i | nib_q;
    strobe_last = byte_done && (idx_q == last_idx);
    load        = head_valid_i & (~valid_q | stb.ready);
    pop_o       = load & strobe_last;

    idx_d   = idx_q;
    nib_d   = nib_q;
    valid_d = valid_q & ~stb.ready;
    rs_d    = rs_q;
    bus_d   = bus_q;
    wait_d  = wait_q;
    last_d  = last_q;

    if (load) begin
      valid_d = 1'b1;
      rs_d    = cur_rs;
      last_d  = strobe_last;
      if (!four_bit_i) begin
        bus_d  = cur_byte;
        wait_d = cur_wait;
      end else if (!nib_q) begin
        bus_d  = {4'b0000, cur_byte[7:4]};
        wait_d = cur_wait;
      end else begin
        bus_d  = {4'b0000, cur_byte[3:0]};
        wait_d = '0;
      end
      if (strobe_last) begin
        idx_d = '0;
        nib_d = 1'b0;
      end else if (byte_done) begin
        idx_d = idx_q + 1'b1;
        nib_d = 1'b0;
      end else begin
        nib_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      nib_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      nib_q   <= nib_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q   <= rs_d;
    bus_q  <= bus_d;
    wait_q <= wait_d;
    last_q <= last_d;
  end

  assign stb.valid           = valid_q;
  assign stb.register_select = rs_q;
  assign stb.bus_value       = bus_q;
  assign stb.wait_before_us  = wait_q;
  assign stb.last            = last_q;

endmodule

/* rtl/core/char_lcd_write_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Character LCD write sequencer
// Expands display requests into runs of register-select/bus/wait strobes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Carries
//  --------+-----------+-----------------------------------------------
//  req     | in        | action, value, row, column, glyph_slot
//  stb     | out       | register_select, bus_value, wait_before_us, last
//  APB     | in        | four_bit_bus at 0x0, enable_pulse_us at 0x4
//
// A request is taken whenever the job queue has room.
// Strobes leave at one per cycle while the receiver takes them; a request
// expands into up to 18 strobes (none for an unknown action; power-up in 4-bit
// mode is the longest); the output register sets the pace.
// Reset empties the queue and the output register and restores the registers.
// Output stalls fill the queue, and only then does req.ready drop.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_core
  import clws_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  clws_req_if.sink          req,
  clws_stb_if.source        stb,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic               four_bit_q;
  logic [BYTE_W-1:0]  pulse_us_q;
  logic               cfg_wr;
  logic               push;
  logic               pop;
  logic               head_valid;
  clws_job_t          job;
  clws_job_t          head;
  clws_queue_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q <= 1'b1;
      pulse_us_q <= PULSE_US_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PULSE_US[2]) begin
        pulse_us_q <= pwdata[BYTE_W-1:0];
      end else begin
        four_bit_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PULSE_US[2]) ? {{(APB_DW-BYTE_W){1'b0}}, pulse_us_q}
                                                : {{(APB_DW-1){1'b0}}, four_bit_q};

  clws_front u_front (
    .req      (req),
    .status_i (status),
    .push_o   (push),
    .job_o    (job)
  );

  clws_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .status_o     (status)
  );

  clws_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .four_bit_i   (four_bit_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .stb          (stb)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.full && status.empty))
    else $error("Job queue reports full and empty together.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |-> !status.full)
    else $error("Request transfer taken while the job queue is full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stb.valid && stb.wait_before_us != '0) |-> !stb.register_select)
    else $error("Strobe with a power-up wait addresses the data register.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("Job retired from an empty queue.");

endmodule

/* tb/char_lcd_write_sequencer_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD write sequencer testbench
// Sends display requests through the request channel and checks every strobe
// against a local expansion of the request. Both bus modes and several enable
// pulse settings are covered. The sender and the receiver pause at random,
// and one long receiver hold-off backs the requests up into the block.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_core_test;
  import clws_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   value;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
    logic [SLOT_W-1:0]   glyph_slot;
  } lcd_req_t;

  typedef struct packed {
    logic              rs;
    logic [BYTE_W-1:0] bus;
    logic [WAIT_W-1:0] wait_us;
    logic              last;
  } lcd_strobe_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  clws_req_if req_ch ();
  clws_stb_if stb_ch ();

  char_lcd_write_sequencer_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .stb    (stb_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  lcd_req_t    requests_pending[$];
  lcd_strobe_t strobes_due[$];
  lcd_strobe_t strobe_run[$];
  lcd_req_t    req_offered;
  logic        bus_four_bit = 1'b1;
  logic        idle_on = 1'b1;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned fail_cnt = 0;

  always #6 clk_i = ~clk_i;

  function automatic void add_byte(logic rs, logic [BYTE_W-1:0] b, logic [WAIT_W-1:0] w);
    if (bus_four_bit) begin
      strobe_run.push_back('{rs, {4'h0, b[7:4]}, w, 1'b0});
      strobe_run.push_back('{rs, {4'h0, b[3:0]}, '0, 1'b0});
    end else begin
      strobe_run.push_back('{rs, b, w, 1'b0});
    end
  endfunction

  function automatic void expand_request(lcd_req_t r);
    logic [BYTE_W-1:0] base;
    strobe_run.delete();
    case (r.action)
      ACT_COMMAND: add_byte(1'b0, r.value, '0);
      ACT_DATA:    add_byte(1'b1, r.value, '0);
      ACT_POSDATA: begin
        if (r.row >= 3'd1 && r.row <= 3'd4) begin
          case (r.row)
            3'd1:    base = ROW1_BASE;
            3'd2:    base = ROW2_BASE;
            3'd3:    base = ROW3_BASE;
            default: base = ROW4_BASE;
          endcase
          add_byte(1'b0, base + {2'b00, r.column} - 8'd1, '0);
        end
        add_byte(1'b1, r.value, '0);
      end
      ACT_POWERUP: begin
        add_byte(1'b0, CMD_FUNC_8BIT, WAIT_POWER_ON);
        add_byte(1'b0, CMD_FUNC_8BIT, WAIT_SECOND);
        add_byte(1'b0, CMD_FUNC_8BIT, WAIT_THIRD);
        add_byte(1'b0, CMD_CLEAR, '0);
        add_byte(1'b0, CMD_HOME, '0);
        add_byte(1'b0, CMD_ENTRY, '0);
        add_byte(1'b0, CMD_DISP_ON, '0);
        add_byte(1'b0, bus_four_bit ? CMD_FUNC_4BIT : CMD_FUNC_8BIT, '0);
        add_byte(1'b0, CMD_DDRAM, '0);
      end
      ACT_GLYPH:   add_byte(1'b0, CMD_CGRAM + {2'b00, r.glyph_slot, 3'b000}, '0);
      default: ;
    endcase
    if (strobe_run.size() != 0) begin
      strobe_run[strobe_run.size() - 1].last = 1'b1;
    end
    foreach (strobe_run[i]) begin
      strobes_due.push_back(strobe_run[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.action <= ACT_COMMAND;
      req_ch.value <= '0;
      req_ch.row <= '0;
      req_ch.column <= '0;
      req_ch.glyph_slot <= '0;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expand_request(req_offered);
        gap_left = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (requests_pending.size() != 0) begin
          req_offered = requests_pending.pop_front();
          req_ch.action <= req_offered.action;
          req_ch.value <= req_offered.value;
          req_ch.row <= req_offered.row;
          req_ch.column <= req_offered.column;
          req_ch.glyph_slot <= req_offered.glyph_slot;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : strobe_monitor
    lcd_strobe_t want;
    if (!rst_ni) begin
      stb_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (stb_ch.valid && stb_ch.ready) begin
        if (strobes_due.size() == 0) begin
          $display("%0t: unexpected strobe rs=%0d bus=%h wait=%0d last=%0d", $time,
                   stb_ch.register_select, stb_ch.bus_value, stb_ch.wait_before_us,
                   stb_ch.last);
          fail_cnt++;
        end else begin
          want = strobes_due.pop_front();
          if (stb_ch.register_select !== want.rs) begin
            $display("%0t: register_select expected %0d, actual %0d", $time, want.rs,
                     stb_ch.register_select);
            fail_cnt++;
          end
          if (stb_ch.bus_value !== want.bus) begin
            $display("%0t: bus_value expected %h, actual %h", $time, want.bus,
                     stb_ch.bus_value);
            fail_cnt++;
          end
          if (stb_ch.wait_before_us !== want.wait_us) begin
            $display("%0t: wait_before_us expected %0d, actual %0d", $time, want.wait_us,
                     stb_ch.wait_before_us);
            fail_cnt++;
          end
          if (stb_ch.last !== want.last) begin
            $display("%0t: last expected %0d, actual %0d", $time, want.last, stb_ch.last);
            fail_cnt++;
          end
        end
        stall_left = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (hold_taken != hold_asked) begin
        hold_left = HOLD_CYCLES;
        hold_taken = hold_asked;
      end
      if (hold_left != 0) begin
        hold_left--;
        stb_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        stb_ch.ready <= 1'b0;
      end else begin
        stb_ch.ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_mode(logic four_bit, logic [BYTE_W-1:0] pulse_us);
    apb_write(REG_FOUR_BIT, {31'd0, four_bit});
    apb_write(REG_PULSE_US, {24'd0, pulse_us});
    bus_four_bit = four_bit;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (requests_pending.size() != 0 || req_ch.valid || strobes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic void queue_req(logic [ACTION_W-1:0] action, logic [BYTE_W-1:0] value,
                                    logic [ROW_W-1:0] row, logic [COL_W-1:0] column,
                                    logic [SLOT_W-1:0] slot);
    requests_pending.push_back('{action, value, row, column, slot});
  endfunction

  function automatic int queue_glyph_definition();
    logic [SLOT_W-1:0] slot;
    slot = SLOT_W'($urandom_range(0, 7));
    queue_req(ACT_GLYPH, BYTE_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 7)),
              COL_W'($urandom_range(0, 63)), slot);
    for (int i = 0; i < 8; i++) begin
      queue_req(ACT_DATA, BYTE_W'($urandom_range(0, 31)), ROW_W'($urandom_range(0, 7)),
                COL_W'($urandom_range(0, 63)), SLOT_W'($urandom_range(0, 7)));
    end
    queue_req(ACT_POSDATA, {5'd0, slot}, ROW_W'($urandom_range(1, 4)),
              COL_W'($urandom_range(1, 20)), SLOT_W'($urandom_range(0, 7)));
    return 10;
  endfunction

  function automatic void queue_random(int count);
    lcd_req_t r;
    int pick;
    int left;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        left -= queue_glyph_definition();
      end else begin
        r.value = BYTE_W'($urandom_range(0, 255));
        r.row = ROW_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                    : $urandom_range(1, 4));
        r.column = COL_W'($urandom_range(0, 63));
        r.glyph_slot = SLOT_W'($urandom_range(0, 7));
        if (pick < 3) begin
          r.action = ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
        end else if (pick < 5) begin
          r.action = ACT_POWERUP;
        end else if (pick < 9) begin
          r.action = ACT_POSDATA;
        end else begin
          r.action = ACTION_W'($urandom_range(ACT_COMMAND, ACT_GLYPH));
        end
        requests_pending.push_back(r);
        left--;
      end
    end
  endfunction

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    // Reset settings: 4-bit bus, default enable pulse.
    queue_req(ACT_COMMAND, 8'h00, 3'd0, 6'd0, 3'd0);
    queue_req(ACT_COMMAND, 8'hFF, 3'd7, 6'd63, 3'd7);
    queue_req(ACT_DATA, 8'h00, 3'd0, 6'd0, 3'd0);
    queue_req(ACT_DATA, 8'hFF, 3'd7, 6'd63, 3'd7);
    queue_req(ACT_POSDATA, 8'h41, 3'd1, 6'd1, 3'd0);
    queue_req(ACT_POSDATA, 8'h42, 3'd2, 6'd0, 3'd0);
    queue_req(ACT_POSDATA, 8'h43, 3'd3, 6'd63, 3'd0);
    queue_req(ACT_POSDATA, 8'h44, 3'd4, 6'd20, 3'd0);
    queue_req(ACT_POSDATA, 8'h45, 3'd0, 6'd5, 3'd0);
    queue_req(ACT_POSDATA, 8'h46, 3'd5, 6'd10, 3'd0);
    queue_req(ACT_POSDATA, 8'h47, 3'd7, 6'd63, 3'd0);
    queue_req(ACT_POWERUP, 8'h00, 3'd0, 6'd0, 3'd0);
    queue_req(ACT_GLYPH, 8'h00, 3'd0, 6'd0, 3'd0);
    queue_req(ACT_GLYPH, 8'hFF, 3'd0, 6'd0, 3'd7);
    for (int a = ACT_FIRST_UNUSED; a <= ACT_LAST_UNUSED; a++) begin
      queue_req(ACTION_W'(a), 8'h55, 3'd1, 6'd1, 3'd1);
    end
    queue_random(25);
    wait_drained();

    // 8-bit bus with the widest enable pulse.
    set_mode(1'b0, 8'd255);
    queue_req(ACT_POWERUP, 8'h00, 3'd0, 6'd0, 3'd0);
    queue_req(ACT_COMMAND, 8'hA5, 3'd0, 6'd0, 3'd0);
    queue_req(ACT_DATA, 8'h5A, 3'd0, 6'd0, 3'd0);
    queue_req(ACT_POSDATA, 8'h30, 3'd4, 6'd0, 3'd0);
    queue_req(ACT_POSDATA, 8'h31, 3'd6, 6'd0, 3'd0);
    queue_req(ACT_GLYPH, 8'h00, 3'd0, 6'd0, 3'd3);
    queue_random(25);
    wait_drained();

    // 4-bit bus, shortest pulse; the receiver holds off so the block backs up.
    set_mode(1'b1, 8'd1);
    hold_asked++;
    queue_random(35);
    wait_drained();

    // No idling on either side.
    idle_on = 1'b0;
    set_mode(1'b0, BYTE_W'($urandom_range(1, 255)));
    queue_random(25);
    wait_drained();

    idle_on = 1'b1;
    set_mode(1'b1, 8'd10);
    queue_random(25);
    wait_drained();

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/clws_pkg.sv
rtl/core/clws_req_if.sv
rtl/core/clws_stb_if.sv
rtl/core/clws_front.sv
rtl/core/clws_fifo.sv
rtl/core/clws_back.sv
rtl/core/char_lcd_write_sequencer_core.sv
tb/char_lcd_write_sequencer_core_test.sv
